>>> hw/rtl/erd_pkg.sv
// Shared types and constants for the escape run-length decoder.
// No dependencies; imported by every module of the block except erd_ram.
package erd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 9;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [LEN_W-1:0]   EXTEND_LENGTH = 9'd259;
   localparam logic [BYTE_W-1:0]  EXT_SHORT_LIMIT = 8'd128;
   localparam logic [COUNT_W-1:0] CHAR_BIAS = 16'd4;

   typedef enum logic [1:0] {
      REG_ESCAPE = 2'd0,
      REG_SINGLE = 2'd1,
      REG_DOUBLE = 2'd2,
      REG_TRIPLE = 2'd3
   } reg_index_type;

   typedef enum logic {
      ACT_STREAM = 1'b0,
      ACT_LOAD   = 1'b1
   } action_type;

   typedef struct packed {
      logic [BYTE_W-1:0] escape_byte;
      logic [BYTE_W-1:0] single_escape_code;
      logic [BYTE_W-1:0] double_escape_code;
      logic [BYTE_W-1:0] triple_escape_code;
   } cfg_type;

   typedef struct packed {
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] char;
   } entry_type;

   typedef struct packed {
      logic [BYTE_W-1:0] stream_byte;
      entry_type         entry;
   } work_type;

endpackage

>>> hw/rtl/erd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module erd_ram #(
   parameter int unsigned WIDTH = 17,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/erd_front.sv
// Front end: accepts input items, writes table loads, looks up every stream byte.
// Depends on erd_pkg and erd_ram.
module erd_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic                                     req_action,
   input  logic [erd_pkg::BYTE_W-1:0]               req_stream_byte,
   input  logic [erd_pkg::BYTE_W-1:0]               req_entry_index,
   input  logic [erd_pkg::LEN_W-1:0]                req_entry_length,
   input  logic [erd_pkg::BYTE_W-1:0]               req_entry_char,
   input  logic [$clog2(erd_pkg::QUEUE_DEPTH+1)-1:0] queue_count,
   output logic                                     push_valid,
   output erd_pkg::work_type                        push_data
);
   import erd_pkg::*;

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);

   logic                   accept;
   logic                   is_load;
   logic                   is_stream;
   logic [CNT_W:0]         in_use;
   entry_type              rd_entry;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   lookup_ff, lookup_in;
   logic                   hit_ff, hit_in;
   logic [BYTE_W-1:0]      byte_ff, byte_in;

   assign in_use     = {1'b0, queue_count} + (CNT_W+1)'(lookup_ff);
   assign req_tready = (in_use < (CNT_W+1)'(QUEUE_DEPTH));
   assign accept     = req_tvalid & req_tready;
   assign is_load    = accept & (req_action == ACT_LOAD);
   assign is_stream  = accept & (req_action == ACT_STREAM);

   erd_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (is_load),
      .wr_addr (req_entry_index[ADDR_W-1:0]),
      .wr_data ({req_entry_length, req_entry_char}),
      .rd_en   (is_stream),
      .rd_addr (req_stream_byte[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   always_comb begin
      valid_in  = valid_ff;
      lookup_in = is_stream;
      hit_in    = hit_ff;
      byte_in   = byte_ff;
      if (is_load) begin
         valid_in[req_entry_index[ADDR_W-1:0]] = 1'b1;
      end
      if (is_stream) begin
         hit_in  = valid_ff[req_stream_byte[ADDR_W-1:0]];
         byte_in = req_stream_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         lookup_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         lookup_ff <= lookup_in;
      end
      hit_ff  <= hit_in;
      byte_ff <= byte_in;
   end

   // An entry never loaded reads as empty
   always_comb begin
      push_valid            = lookup_ff;
      push_data.stream_byte = byte_ff;
      push_data.entry       = hit_ff ? rd_entry : '0;
   end

endmodule

>>> hw/rtl/erd_queue.sv
// Short FIFO between front end and decoder back end.
// Depends on erd_pkg.
module erd_queue (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     push_valid,
   input  erd_pkg::work_type                        push_data,
   output logic                                     pop_valid,
   output erd_pkg::work_type                        pop_data,
   input  logic                                     pop_ready,
   output logic [$clog2(erd_pkg::QUEUE_DEPTH+1)-1:0] count
);
   import erd_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop_valid & pop_ready;
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      case ({push_valid, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/erd_back.sv
// Back end: escape and run decoding state machine with registered result.
// Depends on erd_pkg.
module erd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  erd_pkg::cfg_type              cfg,
   input  logic                          pop_valid,
   input  erd_pkg::work_type             pop_data,
   output logic                          pop_ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [erd_pkg::BYTE_W-1:0]    rsp_run_byte,
   output logic [erd_pkg::COUNT_W-1:0]   rsp_run_count
);
   import erd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CODE,
      ST_CHAR,
      ST_EXT1,
      ST_EXT2
   } state_type;

   state_type          state_ff, state_in;
   logic [BYTE_W-1:0]  char_ff, char_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic               take;
   logic               emit;
   logic [BYTE_W-1:0]  emit_byte;
   logic [COUNT_W-1:0] emit_count;
   logic [BYTE_W-1:0]  b;
   entry_type          ent;

   assign pop_ready = ~out_valid_ff | rsp_tready;
   assign take      = pop_valid & pop_ready;
   assign b         = pop_data.stream_byte;
   assign ent       = pop_data.entry;

   always_comb begin
      state_in   = state_ff;
      char_in    = char_ff;
      count_in   = count_ff;
      emit       = 1'b0;
      emit_byte  = b;
      emit_count = COUNT_W'(1);
      if (take) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (b == cfg.escape_byte) begin
                  state_in = ST_CODE;
               end else begin
                  emit = 1'b1;
               end
            end
            ST_CODE: begin
               state_in  = ST_IDLE;
               emit_byte = cfg.escape_byte;
               if (b == cfg.single_escape_code) begin
                  emit       = 1'b1;
                  emit_count = COUNT_W'(1);
               end else if (b == cfg.double_escape_code) begin
                  emit       = 1'b1;
                  emit_count = COUNT_W'(2);
               end else if (b == cfg.triple_escape_code) begin
                  emit       = 1'b1;
                  emit_count = COUNT_W'(3);
               end else if (ent.length != '0) begin
                  char_in    = ent.char;
                  count_in   = COUNT_W'(ent.length);
                  emit_byte  = ent.char;
                  emit_count = COUNT_W'(ent.length);
                  if (ent.length == EXTEND_LENGTH) begin
                     state_in = ST_EXT1;
                  end else begin
                     emit = 1'b1;
                  end
               end else begin
                  count_in = COUNT_W'(b) + CHAR_BIAS;
                  state_in = ST_CHAR;
               end
            end
            ST_CHAR: begin
               char_in    = b;
               emit_count = count_ff;
               if (count_ff == COUNT_W'(EXTEND_LENGTH)) begin
                  state_in = ST_EXT1;
               end else begin
                  state_in = ST_IDLE;
                  emit     = 1'b1;
               end
            end
            ST_EXT1: begin
               emit_byte = char_ff;
               if (b < EXT_SHORT_LIMIT) begin
                  state_in   = ST_IDLE;
                  emit       = 1'b1;
                  emit_count = COUNT_W'(EXTEND_LENGTH) + COUNT_W'(b);
               end else begin
                  state_in = ST_EXT2;
                  count_in = {1'b0, b[BYTE_W-2:0], {BYTE_W{1'b0}}}
                           + COUNT_W'(EXTEND_LENGTH) + COUNT_W'(EXT_SHORT_LIMIT);
               end
            end
            ST_EXT2: begin
               state_in   = ST_IDLE;
               emit       = 1'b1;
               emit_byte  = char_ff;
               emit_count = count_ff + COUNT_W'(b);
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_count_in = out_count_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_count_in = emit_count;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         char_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         char_ff      <= char_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff  <= out_byte_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_tvalid    = out_valid_ff;
   assign rsp_run_byte  = out_byte_ff;
   assign rsp_run_count = out_count_ff;

endmodule

>>> hw/rtl/escape_rle_decoder_top.sv
// Escape-coded run-length decoder: takes one compressed byte or one table load
// per clock and gives runs as a byte and a 16-bit count. A stream byte passes
// through the registered run-table read, then the four-entry queue, and then the
// decoder state machine, which loads the result register. Sustained rate is one
// item per cycle; the front end stalls only when the queue, counting a lookup in
// flight, fills because results are not being taken. Table entries are empty
// after reset at once, with no clearing pass. The user writes registers through
// the csr_ port only while no item is in flight; the block does not enforce it.
// Depends on erd_pkg, erd_front, erd_queue and erd_back.
module escape_rle_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // stream_byte, entry_index, entry_length, entry_char
   input  logic        req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // run_byte, run_count
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import erd_pkg::*;

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cfg_type            cfg_ff, cfg_in;
   reg_index_type      reg_sel;
   logic               csr_write;
   logic               push_valid;
   work_type           push_data;
   logic               pop_valid;
   logic               pop_ready;
   work_type           pop_data;
   logic [CNT_W-1:0]   queue_count;
   logic [BYTE_W-1:0]  run_byte;
   logic [COUNT_W-1:0] run_count;
   logic [BYTE_W-1:0]  rd_value;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_ESCAPE: cfg_in.escape_byte        = csr_pwdata[BYTE_W-1:0];
            REG_SINGLE: cfg_in.single_escape_code = csr_pwdata[BYTE_W-1:0];
            REG_DOUBLE: cfg_in.double_escape_code = csr_pwdata[BYTE_W-1:0];
            REG_TRIPLE: cfg_in.triple_escape_code = csr_pwdata[BYTE_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ESCAPE: rd_value = cfg_ff.escape_byte;
         REG_SINGLE: rd_value = cfg_ff.single_escape_code;
         REG_DOUBLE: rd_value = cfg_ff.double_escape_code;
         REG_TRIPLE: rd_value = cfg_ff.triple_escape_code;
         default:    rd_value = '0;
      endcase
   end

   assign csr_prdata = {24'd0, rd_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   erd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_action       (req_tuser),
      .req_stream_byte  (req_tdata[7:0]),
      .req_entry_index  (req_tdata[15:8]),
      .req_entry_length (req_tdata[24:16]),
      .req_entry_char   (req_tdata[32:25]),
      .queue_count      (queue_count),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   erd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .count      (queue_count)
   );

   erd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .pop_valid     (pop_valid),
      .pop_data      (pop_data),
      .pop_ready     (pop_ready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_run_byte  (run_byte),
      .rsp_run_count (run_count)
   );

   assign rsp_tdata = {run_count, run_byte};

endmodule
